// File: hdl/segment_intersection_macros.svh
// Assertion macros shared by the checker of the segment intersection block.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SI_IMPLIES(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("segment_intersection: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SI_NEXT(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("segment_intersection: next-cycle check failed");

`endif

// File: hdl/si_pkg.sv
// Package for the segment intersection block: default widths, queue depth
// and the flag group that travels with each item. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package si_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int Q_DEPTH        = 4;

   typedef struct packed {
      logic hit;
      logic parallel;
      logic neg_x;
      logic neg_y;
   } flags_type;

endpackage

`default_nettype wire

// File: hdl/si_front.sv
// Front pipeline: differences, cross products, sign fix, hit test and the
// meeting-point numerators. Depends on si_pkg.
`timescale 1ns / 1ps
`default_nettype none

module si_front #(
   parameter int COORD_BITS = si_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = si_pkg::FRAC_BITS_DEF,
   localparam int DW   = COORD_BITS + 1,
   localparam int PW   = 2 * DW,
   localparam int XW   = PW + 1,
   localparam int DENW = XW - 1,
   localparam int NW   = DW + XW + 1,
   localparam int QW   = NW + FRAC_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_push,
   output logic                              in_full,
   input  wire logic signed [COORD_BITS-1:0] in_sax,
   input  wire logic signed [COORD_BITS-1:0] in_say,
   input  wire logic signed [COORD_BITS-1:0] in_eax,
   input  wire logic signed [COORD_BITS-1:0] in_eay,
   input  wire logic signed [COORD_BITS-1:0] in_sbx,
   input  wire logic signed [COORD_BITS-1:0] in_sby,
   input  wire logic signed [COORD_BITS-1:0] in_ebx,
   input  wire logic signed [COORD_BITS-1:0] in_eby,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [QW-1:0]                     out_mag_x,
   output logic [QW-1:0]                     out_mag_y,
   output logic [DENW-1:0]                   out_den,
   output si_pkg::flags_type                 out_flags
);

   localparam int STAGES = 8;

   logic [STAGES-1:0] v_ff, v_in;
   logic en;

   assign en      = !v_ff[STAGES-1] || out_ready;
   assign in_full = !en;
   assign v_in    = {v_ff[STAGES-2:0], in_push && en};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   function automatic logic signed [DW-1:0] sxt(input logic signed [COORD_BITS-1:0] a);
      return DW'(a);
   endfunction

   // Stage 0: input capture.
   logic signed [COORD_BITS-1:0] sax_ff, say_ff, eax_ff, eay_ff;
   logic signed [COORD_BITS-1:0] sbx_ff, sby_ff, ebx_ff, eby_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sax_ff <= in_sax; say_ff <= in_say; eax_ff <= in_eax; eay_ff <= in_eay;
         sbx_ff <= in_sbx; sby_ff <= in_sby; ebx_ff <= in_ebx; eby_ff <= in_eby;
      end
   end

   // Stage 1: direction and offset vectors.
   logic signed [COORD_BITS-1:0] px1_ff, py1_ff;
   logic signed [DW-1:0] rx1_ff, ry1_ff, sx1_ff, sy1_ff, dx1_ff, dy1_ff;
   logic signed [DW-1:0] rx1_in, ry1_in, sx1_in, sy1_in, dx1_in, dy1_in;
   assign rx1_in = sxt(eax_ff) - sxt(sax_ff);
   assign ry1_in = sxt(eay_ff) - sxt(say_ff);
   assign sx1_in = sxt(ebx_ff) - sxt(sbx_ff);
   assign sy1_in = sxt(eby_ff) - sxt(sby_ff);
   assign dx1_in = sxt(sbx_ff) - sxt(sax_ff);
   assign dy1_in = sxt(sby_ff) - sxt(say_ff);
   always_ff @(posedge clock) begin
      if (en) begin
         px1_ff <= sax_ff; py1_ff <= say_ff;
         rx1_ff <= rx1_in; ry1_ff <= ry1_in; sx1_ff <= sx1_in; sy1_ff <= sy1_in;
         dx1_ff <= dx1_in; dy1_ff <= dy1_in;
      end
   end

   // Stage 2: the six partial products.
   logic signed [COORD_BITS-1:0] px2_ff, py2_ff;
   logic signed [DW-1:0] rx2_ff, ry2_ff;
   logic signed [PW-1:0] pd1_ff, pd2_ff, pt1_ff, pt2_ff, pu1_ff, pu2_ff;
   logic signed [PW-1:0] pd1_in, pd2_in, pt1_in, pt2_in, pu1_in, pu2_in;
   assign pd1_in = rx1_ff * sy1_ff;
   assign pd2_in = ry1_ff * sx1_ff;
   assign pt1_in = dx1_ff * sy1_ff;
   assign pt2_in = dy1_ff * sx1_ff;
   assign pu1_in = dx1_ff * ry1_ff;
   assign pu2_in = dy1_ff * rx1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         px2_ff <= px1_ff; py2_ff <= py1_ff; rx2_ff <= rx1_ff; ry2_ff <= ry1_ff;
         pd1_ff <= pd1_in; pd2_ff <= pd2_in; pt1_ff <= pt1_in;
         pt2_ff <= pt2_in; pu1_ff <= pu1_in; pu2_ff <= pu2_in;
      end
   end

   // Stage 3: cross products.
   logic signed [COORD_BITS-1:0] px3_ff, py3_ff;
   logic signed [DW-1:0] rx3_ff, ry3_ff;
   logic signed [XW-1:0] den3_ff, tn3_ff, un3_ff, den3_in, tn3_in, un3_in;
   assign den3_in = pd1_ff - pd2_ff;
   assign tn3_in  = pt1_ff - pt2_ff;
   assign un3_in  = pu1_ff - pu2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         px3_ff <= px2_ff; py3_ff <= py2_ff; rx3_ff <= rx2_ff; ry3_ff <= ry2_ff;
         den3_ff <= den3_in; tn3_ff <= tn3_in; un3_ff <= un3_in;
      end
   end

   // Stage 4: make the denominator positive, then test both parameters.
   logic signed [COORD_BITS-1:0] px4_ff, py4_ff;
   logic signed [DW-1:0] rx4_ff, ry4_ff;
   logic signed [XW-1:0] den4_ff, tn4_ff, den4_in, tn4_in, un4_in;
   logic hit4_ff, par4_ff, hit4_in;
   assign den4_in = den3_ff[XW-1] ? -den3_ff : den3_ff;
   assign tn4_in  = den3_ff[XW-1] ? -tn3_ff  : tn3_ff;
   assign un4_in  = den3_ff[XW-1] ? -un3_ff  : un3_ff;
   assign hit4_in = !tn4_in[XW-1] && (tn4_in <= den4_in) &&
                    !un4_in[XW-1] && (un4_in <= den4_in);
   always_ff @(posedge clock) begin
      if (en) begin
         px4_ff <= px3_ff; py4_ff <= py3_ff; rx4_ff <= rx3_ff; ry4_ff <= ry3_ff;
         den4_ff <= den4_in; tn4_ff <= tn4_in;
         hit4_ff <= hit4_in; par4_ff <= (den3_ff == '0);
      end
   end

   // Stage 5: base * den and dir * t numerator, per coordinate.
   logic signed [COORD_BITS+XW-1:0] m1x5_ff, m1y5_ff, m1x5_in, m1y5_in;
   logic signed [DW+XW-1:0]         m2x5_ff, m2y5_ff, m2x5_in, m2y5_in;
   logic signed [XW-1:0] den5_ff;
   logic hit5_ff, par5_ff;
   assign m1x5_in = px4_ff * den4_ff;
   assign m1y5_in = py4_ff * den4_ff;
   assign m2x5_in = rx4_ff * tn4_ff;
   assign m2y5_in = ry4_ff * tn4_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         m1x5_ff <= m1x5_in; m1y5_ff <= m1y5_in; m2x5_ff <= m2x5_in; m2y5_ff <= m2y5_in;
         den5_ff <= den4_ff; hit5_ff <= hit4_ff; par5_ff <= par4_ff;
      end
   end

   // Stage 6: full numerators.
   logic signed [NW-1:0] nx6_ff, ny6_ff, nx6_in, ny6_in;
   logic signed [NW-1:0] ax6, bx6, ay6, by6;
   logic signed [XW-1:0] den6_ff;
   logic hit6_ff, par6_ff;
   assign ax6 = NW'(m1x5_ff);
   assign bx6 = NW'(m2x5_ff);
   assign ay6 = NW'(m1y5_ff);
   assign by6 = NW'(m2y5_ff);
   assign nx6_in = ax6 + bx6;
   assign ny6_in = ay6 + by6;
   always_ff @(posedge clock) begin
      if (en) begin
         nx6_ff <= nx6_in; ny6_ff <= ny6_in;
         den6_ff <= den5_ff; hit6_ff <= hit5_ff; par6_ff <= par5_ff;
      end
   end

   // Stage 7: magnitude and sign, scaled by the fraction bits.
   logic [NW-1:0] absx, absy;
   logic [QW-1:0] magx_ff, magy_ff;
   logic [DENW-1:0] den7_ff;
   si_pkg::flags_type fl7_ff, fl7_in;
   assign absx = nx6_ff[NW-1] ? -nx6_ff : nx6_ff;
   assign absy = ny6_ff[NW-1] ? -ny6_ff : ny6_ff;
   always_comb begin
      fl7_in.hit      = hit6_ff;
      fl7_in.parallel = par6_ff;
      fl7_in.neg_x    = nx6_ff[NW-1];
      fl7_in.neg_y    = ny6_ff[NW-1];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         magx_ff <= QW'(absx) << FRAC_BITS;
         magy_ff <= QW'(absy) << FRAC_BITS;
         den7_ff <= den6_ff[DENW-1:0];
         fl7_ff  <= fl7_in;
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_mag_x = magx_ff;
   assign out_mag_y = magy_ff;
   assign out_den   = den7_ff;
   assign out_flags = fl7_ff;

endmodule

`default_nettype wire

// File: hdl/si_queue.sv
// Short register queue between the front and back pipelines.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module si_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ff];

endmodule

`default_nettype wire

// File: hdl/si_back.sv
// Back pipeline: one restoring divide stage per quotient bit for each
// coordinate, then rounding, saturation and the result register. Uses si_pkg.
`timescale 1ns / 1ps
`default_nettype none

module si_back #(
   parameter int COORD_BITS = si_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = si_pkg::FRAC_BITS_DEF,
   localparam int DW   = COORD_BITS + 1,
   localparam int XW   = 2 * DW + 1,
   localparam int DENW = XW - 1,
   localparam int NW   = DW + XW + 1,
   localparam int QW   = NW + FRAC_BITS,
   localparam int EW   = (QW + 1 > 33) ? QW + 1 : 33
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_pop,
   input  wire logic [QW-1:0]     in_mag_x,
   input  wire logic [QW-1:0]     in_mag_y,
   input  wire logic [DENW-1:0]   in_den,
   input  wire si_pkg::flags_type in_flags,
   output logic                   out_empty,
   input  wire logic              out_pop,
   output logic                   out_hit,
   output logic                   out_parallel,
   output logic [31:0]            out_meet_x,
   output logic [31:0]            out_meet_y,
   output logic                   out_clipped
);

   logic en;
   logic out_v_ff;
   logic [QW:0] v_ff;

   assign en     = !out_v_ff || out_pop;
   assign in_pop = en && in_valid;

   logic [DENW-1:0] rx_ff [QW+1];
   logic [DENW-1:0] ry_ff [QW+1];
   logic [QW-1:0]   nqx_ff [QW+1];
   logic [QW-1:0]   nqy_ff [QW+1];
   logic [DENW-1:0] den_ff [QW+1];
   si_pkg::flags_type fl_ff [QW+1];

   // Remainder on top, dividend bits shift out at the top of nq while
   // quotient bits enter at the bottom.
   function automatic logic [DENW+QW-1:0] div_step(input logic [DENW-1:0] r,
                                                   input logic [QW-1:0] nq,
                                                   input logic [DENW-1:0] d);
      logic [DENW:0] t;
      logic [DENW:0] diff;
      logic qb;
      t    = {r, nq[QW-1]};
      diff = t - {1'b0, d};
      qb   = (t >= {1'b0, d});
      return {(qb ? diff[DENW-1:0] : t[DENW-1:0]), nq[QW-2:0], qb};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v_ff     <= {v_ff[QW-1:0], in_valid};
         out_v_ff <= v_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0]  <= '0;
         ry_ff[0]  <= '0;
         nqx_ff[0] <= in_mag_x;
         nqy_ff[0] <= in_mag_y;
         den_ff[0] <= in_den;
         fl_ff[0]  <= in_flags;
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_div
      logic [DENW+QW-1:0] stx, sty;
      assign stx = div_step(rx_ff[s-1], nqx_ff[s-1], den_ff[s-1]);
      assign sty = div_step(ry_ff[s-1], nqy_ff[s-1], den_ff[s-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[s]  <= stx[DENW+QW-1:QW];
            nqx_ff[s] <= stx[QW-1:0];
            ry_ff[s]  <= sty[DENW+QW-1:QW];
            nqy_ff[s] <= sty[QW-1:0];
            den_ff[s] <= den_ff[s-1];
            fl_ff[s]  <= fl_ff[s-1];
         end
      end
   end

   // Round half away from zero on the magnitude, then clamp to 32 bits.
   function automatic logic [32:0] round_sat(input logic [DENW-1:0] rem,
                                             input logic [QW-1:0] q,
                                             input logic [DENW-1:0] d,
                                             input logic neg);
      logic [EW-1:0] qr;
      logic [EW-1:0] lim;
      logic rup;
      rup = ({rem, 1'b0} >= {1'b0, d});
      qr  = EW'(q) + EW'(rup);
      lim = neg ? (EW'(1) << 31) : ((EW'(1) << 31) - EW'(1));
      if (qr > lim) begin
         return {1'b1, (neg ? 32'h8000_0000 : 32'h7FFF_FFFF)};
      end
      return {1'b0, (neg ? (32'd0 - qr[31:0]) : qr[31:0])};
   endfunction

   logic [32:0] rsx, rsy;
   logic hit_ff, par_ff, clip_ff;
   logic [31:0] mx_ff, my_ff;
   si_pkg::flags_type fl_last;

   assign fl_last = fl_ff[QW];
   assign rsx = round_sat(rx_ff[QW], nqx_ff[QW], den_ff[QW], fl_last.neg_x);
   assign rsy = round_sat(ry_ff[QW], nqy_ff[QW], den_ff[QW], fl_last.neg_y);

   always_ff @(posedge clock) begin
      if (en) begin
         if (fl_last.parallel) begin
            hit_ff  <= 1'b0;
            par_ff  <= 1'b1;
            mx_ff   <= '0;
            my_ff   <= '0;
            clip_ff <= 1'b0;
         end else begin
            hit_ff  <= fl_last.hit;
            par_ff  <= 1'b0;
            mx_ff   <= rsx[31:0];
            my_ff   <= rsy[31:0];
            clip_ff <= rsx[32] || rsy[32];
         end
      end
   end

   assign out_empty    = !out_v_ff;
   assign out_hit      = hit_ff;
   assign out_parallel = par_ff;
   assign out_meet_x   = mx_ff;
   assign out_meet_y   = my_ff;
   assign out_clipped  = clip_ff;

endmodule

`default_nettype wire

// File: hdl/segment_intersection.sv
// Path of an accepted item to its result: 8 front stages,
// the queue, an input register, 3*COORD_BITS+FRAC_BITS+5 divide stages
// (61 by default) and the result register.
// Throughput: one item per cycle without stalls; the divider has one stage per quotient bit.
// A result stall holds the back pipeline; the 4-entry queue keeps the front going until full.
// Reset (synchronous, active high) empties the pipelines and the queue.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection #(
   parameter int COORD_BITS = si_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = si_pkg::FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_end_y,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic                              rsp_hit,
   output logic                              rsp_parallel,
   output logic signed [31:0]                rsp_meet_x,
   output logic signed [31:0]                rsp_meet_y,
   output logic                              rsp_clipped
);

   localparam int DW   = COORD_BITS + 1;
   localparam int XW   = 2 * DW + 1;
   localparam int DENW = XW - 1;
   localparam int NW   = DW + XW + 1;
   localparam int QW   = NW + FRAC_BITS;
   localparam int FLW  = $bits(si_pkg::flags_type);
   localparam int QDW  = 2 * QW + DENW + FLW;

   logic f_valid, q_full, q_empty, q_pop;
   logic [QW-1:0] f_mag_x, f_mag_y, b_mag_x, b_mag_y;
   logic [DENW-1:0] f_den, b_den;
   si_pkg::flags_type f_flags, b_flags;
   logic [QDW-1:0] q_wdata, q_rdata;
   logic [31:0] meet_x, meet_y;

   si_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_push(req_push), .in_full(req_full),
      .in_sax(req_seg_a_start_x), .in_say(req_seg_a_start_y),
      .in_eax(req_seg_a_end_x),   .in_eay(req_seg_a_end_y),
      .in_sbx(req_seg_b_start_x), .in_sby(req_seg_b_start_y),
      .in_ebx(req_seg_b_end_x),   .in_eby(req_seg_b_end_y),
      .out_valid(f_valid), .out_ready(!q_full),
      .out_mag_x(f_mag_x), .out_mag_y(f_mag_y), .out_den(f_den), .out_flags(f_flags)
   );

   assign q_wdata = {f_mag_x, f_mag_y, f_den, f_flags};

   si_queue #(.WIDTH(QDW), .DEPTH(si_pkg::Q_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .push_data(q_wdata), .full(q_full),
      .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
   );

   assign {b_mag_x, b_mag_y, b_den, b_flags} = q_rdata;

   si_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(!q_empty), .in_pop(q_pop),
      .in_mag_x(b_mag_x), .in_mag_y(b_mag_y), .in_den(b_den), .in_flags(b_flags),
      .out_empty(rsp_empty), .out_pop(rsp_pop),
      .out_hit(rsp_hit), .out_parallel(rsp_parallel),
      .out_meet_x(meet_x), .out_meet_y(meet_y), .out_clipped(rsp_clipped)
   );

   assign rsp_meet_x = meet_x;
   assign rsp_meet_y = meet_y;

endmodule

`default_nettype wire

// File: hdl/si_checker.sv
// Port-level checker for segment_intersection, bound to the top level.
// Uses the macros in segment_intersection_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_intersection_macros.svh"

module si_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic        rsp_hit,
   input wire logic        rsp_parallel,
   input wire logic [31:0] rsp_meet_x,
   input wire logic [31:0] rsp_meet_y,
   input wire logic        rsp_clipped
);

   // Parallel lines give no hit and a zero point.
   `SI_IMPLIES(a_parallel_zero, !rsp_empty && rsp_parallel, !rsp_hit && rsp_meet_x == 32'd0 && rsp_meet_y == 32'd0 && !rsp_clipped)

   // A clipped item carries at least one coordinate at a rail.
   `SI_IMPLIES(a_clip_rail, !rsp_empty && rsp_clipped, rsp_meet_x == 32'h7FFF_FFFF || rsp_meet_x == 32'h8000_0000 || rsp_meet_y == 32'h7FFF_FFFF || rsp_meet_y == 32'h8000_0000)

   // A waiting item that is not taken stays put.
   `SI_NEXT(a_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_meet_x) && $stable(rsp_meet_y) && $stable(rsp_hit))

endmodule

bind segment_intersection si_checker u_si_checker (.*);

`default_nettype wire

// File: verif/tb_segment_intersection.sv
// Testbench for segment_intersection: drives segment pairs through the push/full
// queue port, predicts hit, parallel, meeting point and clipping, checks results.
// Depends on si_pkg and the segment_intersection RTL.
`timescale 1ns / 1ps

class meet_scoreboard;
   typedef struct {
      bit hit;
      bit parallel;
      bit signed [31:0] meet_x;
      bit signed [31:0] meet_y;
      bit clipped;
   } meet_result_type;

   meet_result_type pending[$];
   int mismatches;

   // Exact meeting coordinate: (base*den + dir*num) * 2^8 / den, rounded half away
   // from zero, then saturated to 32 bits. den is positive here.
   function automatic bit signed [31:0] meet_coord(longint base, longint dir, longint num,
                                                   longint den, ref bit clip);
      logic signed [127:0] n, q, r, mag;
      bit neg;
      n = (128'(signed'(base)) * 128'(signed'(den)) + 128'(signed'(dir)) * 128'(signed'(num)));
      neg = n[127];
      mag = neg ? -n : n;
      mag = mag <<< 8;
      q = mag / den;
      r = mag % den;
      if (r >= den - r) q = q + 1;
      if (!neg && q > 128'sh7FFFFFFF) begin
         clip = 1;
         return 32'sh7FFFFFFF;
      end
      if (neg && q > 128'sh80000000) begin
         clip = 1;
         return 32'sh80000000;
      end
      return neg ? -q[31:0] : q[31:0];
   endfunction

   function void note_segments(logic signed [15:0] c[8]);
      meet_result_type e;
      longint px, py, rx, ry, qx, qy, sx, sy, dx, dy, den, tn, un;
      bit clip;
      px = c[0]; py = c[1]; rx = longint'(c[2]) - px; ry = longint'(c[3]) - py;
      qx = c[4]; qy = c[5]; sx = longint'(c[6]) - qx; sy = longint'(c[7]) - qy;
      dx = qx - px; dy = qy - py;
      den = rx * sy - ry * sx;
      tn = dx * sy - dy * sx;
      un = dx * ry - dy * rx;
      e = '{0, 0, 0, 0, 0};
      clip = 0;
      if (den == 0) begin
         e.parallel = 1;
      end else begin
         if (den < 0) begin
            den = -den; tn = -tn; un = -un;
         end
         e.meet_x = meet_coord(px, rx, tn, den, clip);
         e.meet_y = meet_coord(py, ry, tn, den, clip);
         e.hit = (tn >= 0 && tn <= den && un >= 0 && un <= den);
         e.clipped = clip;
      end
      pending.push_back(e);
   endfunction

   function void check_result(bit hit, bit parallel, bit signed [31:0] mx,
                              bit signed [31:0] my, bit clipped);
      meet_result_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result item at %0t", $realtime);
         return;
      end
      e = pending.pop_front();
      if (e.hit !== hit || e.parallel !== parallel || e.meet_x !== mx || e.meet_y !== my
          || e.clipped !== clipped) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch at %0t: expected hit=%0d par=%0d x=%0d y=%0d clip=%0d, got hit=%0d par=%0d x=%0d y=%0d clip=%0d",
                     $realtime, e.hit, e.parallel, e.meet_x, e.meet_y, e.clipped,
                     hit, parallel, mx, my, clipped);
      end
   endfunction
endclass

module tb_segment_intersection;
   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic signed [15:0] coord[8];
   logic rsp_empty;
   logic rsp_pop = 0;
   logic rsp_hit, rsp_parallel, rsp_clipped;
   logic signed [31:0] rsp_meet_x, rsp_meet_y;

   meet_scoreboard board = new();
   bit hold_pop = 0;
   bit calm = 0;
   bit sending_done = 0;

   segment_intersection dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_seg_a_start_x(coord[0]), .req_seg_a_start_y(coord[1]),
      .req_seg_a_end_x(coord[2]), .req_seg_a_end_y(coord[3]),
      .req_seg_b_start_x(coord[4]), .req_seg_b_start_y(coord[5]),
      .req_seg_b_end_x(coord[6]), .req_seg_b_end_y(coord[7]),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_hit(rsp_hit), .rsp_parallel(rsp_parallel),
      .rsp_meet_x(rsp_meet_x), .rsp_meet_y(rsp_meet_y), .rsp_clipped(rsp_clipped)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      foreach (coord[i]) coord[i] = 0;
   end

   // Offers one item, possibly after a random idle burst, and waits for acceptance.
   // Push stays high afterwards so that items can follow back to back.
   task automatic push_segments(logic signed [15:0] c[8]);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_push <= 0;
         repeat (gap) @(negedge clock);
      end
      coord = c;
      req_push <= 1;
      do @(posedge clock); while (req_full);
      board.note_segments(c);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 40)) - 16'sd20;
         2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return 16'($urandom_range(0, 2000)) - 16'sd1000;
      endcase
   endfunction

   task automatic push_pair(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
      logic signed [15:0] c[8];
      c = '{16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(cx), 16'(cy), 16'(dx), 16'(dy)};
      push_segments(c);
   endtask

   // Result side: random pop stalls, long hold when asked.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_pop) begin
            rsp_pop <= 0;
            repeat (600) @(negedge clock);
            hold_pop = 0;
         end
         if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_pop <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1;
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            board.check_result(rsp_hit, rsp_parallel, rsp_meet_x, rsp_meet_y, rsp_clipped);
         @(negedge clock);
      end
   end

   initial begin
      logic signed [15:0] c[8];
      int mode, wait_cycles;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed items: crossings, touching ends, parallel, collinear, degenerate,
      // negative denominator, extremes and saturation.
      push_pair(0, 0, 10, 10, 0, 10, 10, 0);
      push_pair(0, 10, 10, 0, 0, 0, 10, 10);
      push_pair(0, 0, 10, 0, 10, 0, 10, 10);
      push_pair(0, 0, 10, 0, 0, 5, 10, 5);
      push_pair(0, 0, 10, 0, 20, 0, 30, 0);
      push_pair(3, 3, 3, 3, 0, 0, 5, 5);
      push_pair(3, 3, 3, 3, 7, 7, 7, 7);
      push_pair(0, 0, 1, 0, 5, -3, 5, 3);
      push_pair(0, 0, 3, 0, 1, 1, 2, 2);
      push_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      push_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
      push_pair(-32768, 0, -32767, 1, 32767, 0, 32767, 1);
      push_pair(0, 0, 1, 1, 32767, -32768, 32766, -32768);
      push_pair(-32768, -32768, -32768, -32767, 32767, 32767, 32766, 32767);
      push_pair(0, 0, 1, 0, 0, 1, 1, 2);
      push_pair(0, 0, 3, 1, 1, 0, 0, 1);
      push_pair(-1, -1, -1, -1, -1, -1, -1, -1);
      push_pair(0, 0, 0, 0, 0, 0, 0, 0);
      push_pair(-5, 7, 9, -3, 2, -8, -6, 11);
      // Long result stall while items keep coming, enough to fill the block.
      hold_pop = 1;
      for (int i = 0; i < 120; i++) begin
         foreach (c[k]) c[k] = rand_coord(3);
         push_segments(c);
      end
      req_push <= 0;
      // Sender pause until everything is back.
      while (board.pending.size() != 0) @(negedge clock);
      for (int i = 0; i < 510; i++) begin
         if (i == 420) calm = 1;
         mode = $urandom_range(0, 5);
         foreach (c[k]) c[k] = rand_coord(mode > 3 ? 1 : mode);
         // Sometimes force parallel or shared endpoints.
         if ($urandom_range(0, 9) == 0) begin
            c[6] = c[4] + (c[2] - c[0]);
            c[7] = c[5] + (c[3] - c[1]);
         end else if ($urandom_range(0, 9) == 0) begin
            c[4] = c[2]; c[5] = c[3];
         end
         push_segments(c);
      end
      req_push <= 0;
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (100) @(negedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
